FILE: rtl/ct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_pkg: shared types and constants for checkpoint thinning
// Field widths, register indexes, sequencer states and the structs that
// travel between the sequencer, the checkpoint store and the gap unit.
// ----------------------------------------------------------------------------
package ct_pkg;

  localparam int FRONTIER_W = 32;
  localparam int SRC_W      = 5;
  localparam int MAXK_W     = 6;
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 3;

  localparam logic [MAXK_W-1:0]     MAX_KEPT_RST = 6'd8;
  localparam logic [FRONTIER_W-1:0] MIN_STEP_RST = '0;

  // Register index, taken from the word address bit of paddr
  localparam logic REG_MAX_KEPT = 1'b0;
  localparam logic REG_MIN_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SP_SCAN,
    ST_SP_END,
    ST_RM_CHK,
    ST_RM_SCAN,
    ST_RM_END,
    ST_EMIT,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic [FRONTIER_W-1:0] frontier;
    logic                  turn;
  } entry_t;

  typedef struct packed {
    logic [FRONTIER_W-1:0] cur;
    logic [FRONTIER_W-1:0] prev;
    logic                  halve;
    logic [FRONTIER_W-1:0] limit;
  } unit_req_t;

  typedef struct packed {
    logic [FRONTIER_W-1:0] weight;
    logic                  below;
  } unit_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/ct_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_store: checkpoint memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ct_store
  import ct_pkg::*;
#(
  parameter int DEPTH = 32,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/ct_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ct_unit: shared gap and compare unit
// Subtract the predecessor frontier, halve on request, compare to a limit.
// ----------------------------------------------------------------------------
module ct_unit
  import ct_pkg::*;
(
  input  wire unit_req_t req,
  output unit_rsp_t      rsp
);

  logic [FRONTIER_W-1:0] gap;

  assign gap        = req.cur - req.prev;
  assign rsp.weight = req.halve ? (gap >> 1) : gap;
  assign rsp.below  = rsp.weight < req.limit;

endmodule
`default_nettype wire

FILE: rtl/checkpoint_thinning.sv
`default_nettype none
// ----------------------------------------------------------------------------
// checkpoint_thinning: checkpoint list loader and thinner
// Collects checkpoints, drops closely spaced ones, removes the lightest
// historical ones down to a configured count and streams out the survivors.
// ----------------------------------------------------------------------------
// Checkpoints are loaded one per cycle into a MAX_CHECKPOINTS-deep memory
// while in_ready is high; loads beyond capacity are dropped and flagged on
// every result of that list. The transfer carrying in_last_in starts
// thinning, and in_ready stays low until the last survivor has been loaded
// into the output register. All thinning work runs over a single memory read
// port and one shared subtract/compare unit, one stored checkpoint per cycle.
// A spacing pass runs first when min_step is nonzero, then each removal
// scans the kept checkpoints for the lightest one, and emission steps past
// dropped entries and loads each survivor into the output register once it
// is empty or out_ready is high. Registers: max_kept at byte address 0,
// min_step at 4; write them only while the block is idle.
// ----------------------------------------------------------------------------
module checkpoint_thinning
  import ct_pkg::*;
#(
  parameter int MAX_CHECKPOINTS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // checkpoint input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FRONTIER_W-1:0] in_frontier,
  input  wire logic                  in_turn_boundary,
  input  wire logic                  in_last_in,
  // survivor output
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [FRONTIER_W-1:0]      out_kept_frontier,
  output logic                       out_kept_turn,
  output logic [SRC_W-1:0]           out_source_index,
  output logic                       out_last_out,
  output logic                       out_overflow,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_AW-1:0]     paddr,
  input  wire logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]          prdata,
  output logic                       pready
);

  localparam int IDX_W = $clog2(MAX_CHECKPOINTS);
  localparam int CNT_W = $clog2(MAX_CHECKPOINTS + 1);

  // configuration registers
  logic [MAXK_W-1:0]     max_kept_r;
  logic [FRONTIER_W-1:0] min_step_r;

  // sequencer state
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      load_cnt_r, load_cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [MAX_CHECKPOINTS-1:0] kept_mask_r, kept_mask_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [FRONTIER_W-1:0] prev_r, prev_nxt;
  logic [FRONTIER_W-1:0] best_w_r, best_w_nxt;
  logic [IDX_W-1:0]      best_r, best_nxt;
  logic                  first_r, first_nxt;
  logic                  pipe_vld_r, pipe_vld_nxt;
  logic [IDX_W-1:0]      pipe_idx_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load;
  logic [FRONTIER_W-1:0] out_frontier_r;
  logic                  out_turn_r;
  logic [SRC_W-1:0]      out_src_r;
  logic                  out_last_r;
  logic                  out_ovf_r;

  // store and unit connections
  logic                  wr_en;
  entry_t                wr_data;
  entry_t                rd_data;
  unit_req_t             unit_req;
  unit_rsp_t             unit_rsp;

  logic                  in_xfer;
  logic                  cfg_wr;
  logic [IDX_W-1:0]      last_idx;
  logic [IDX_W-1:0]      last_cand;
  logic                  spacing_mode;
  logic [7:0]            keep_limit;

  assign in_xfer   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_LOAD);
  assign last_idx  = IDX_W'(load_cnt_r - CNT_W'(1));
  assign last_cand = IDX_W'(load_cnt_r - CNT_W'(2));
  assign spacing_mode = (state_r == ST_SP_SCAN) || (state_r == ST_SP_END);
  assign keep_limit   = 8'(max_kept_r) + 8'd1;

  // --------------------------------------------------------------------------
  // Configuration port: zero wait states, decode on the word address bit
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_kept_r <= MAX_KEPT_RST;
      min_step_r <= MIN_STEP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_KEPT) begin
        max_kept_r <= pwdata[MAXK_W-1:0];
      end else begin
        min_step_r <= pwdata[FRONTIER_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MIN_STEP) begin
      prdata = min_step_r;
    end else begin
      prdata = CFG_DW'(max_kept_r);
    end
  end

  // --------------------------------------------------------------------------
  // Checkpoint store: written on load transfers that find room, read at ptr
  // --------------------------------------------------------------------------
  assign wr_en            = in_xfer && (load_cnt_r != CNT_W'(MAX_CHECKPOINTS));
  assign wr_data.frontier = in_frontier;
  assign wr_data.turn     = in_turn_boundary;

  ct_store #(
    .DEPTH (MAX_CHECKPOINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(load_cnt_r)),
    .wr_data (wr_data),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  // Spacing compares the raw gap to min_step; removal compares the weight
  // to the lightest one found so far.
  assign unit_req.cur   = rd_data.frontier;
  assign unit_req.prev  = prev_r;
  assign unit_req.halve = !spacing_mode && !rd_data.turn;
  assign unit_req.limit = spacing_mode ? min_step_r : best_w_r;

  ct_unit u_unit (
    .req (unit_req),
    .rsp (unit_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      kept_mask_r <= '0;
      n_r         <= '0;
      ptr_r       <= '0;
      first_r     <= 1'b0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      ovf_r       <= ovf_nxt;
      kept_mask_r <= kept_mask_nxt;
      n_r         <= n_nxt;
      ptr_r       <= ptr_nxt;
      first_r     <= first_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    best_w_r   <= best_w_nxt;
    best_r     <= best_nxt;
    pipe_idx_r <= ptr_r;
    if (out_load) begin
      out_frontier_r <= rd_data.frontier;
      out_turn_r     <= rd_data.turn;
      out_src_r      <= SRC_W'(ptr_r);
      out_last_r     <= (ptr_r == last_idx);
      out_ovf_r      <= ovf_r;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] lc_new;

    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    ovf_nxt       = ovf_r;
    kept_mask_nxt = kept_mask_r;
    n_nxt         = n_r;
    ptr_nxt       = ptr_r;
    prev_nxt      = prev_r;
    best_w_nxt    = best_w_r;
    best_nxt      = best_r;
    first_nxt     = first_r;
    pipe_vld_nxt  = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    lc_new        = load_cnt_r;

    // Fold in the checkpoint read last cycle; spacing keeps entries whose
    // gap reaches min_step, removal tracks the lightest kept candidate.
    if (pipe_vld_r) begin
      if (spacing_mode) begin
        if (!unit_rsp.below) begin
          kept_mask_nxt[pipe_idx_r] = 1'b1;
          prev_nxt = rd_data.frontier;
          n_nxt    = n_r + CNT_W'(1);
        end
      end else if (kept_mask_r[pipe_idx_r]) begin
        if (first_r || unit_rsp.below) begin
          best_w_nxt = unit_rsp.weight;
          best_nxt   = pipe_idx_r;
          first_nxt  = 1'b0;
        end
        prev_nxt = rd_data.frontier;
      end
    end

    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (load_cnt_r == CNT_W'(MAX_CHECKPOINTS)) begin
            ovf_nxt = 1'b1;
          end else begin
            lc_new = load_cnt_r + CNT_W'(1);
          end
          load_cnt_nxt = lc_new;
          if (in_last_in) begin
            ptr_nxt  = '0;
            prev_nxt = '0;
            if ((lc_new <= CNT_W'(1)) || (min_step_r == '0)) begin
              // keep everything, go straight to removal
              for (int i = 0; i < MAX_CHECKPOINTS; i++) begin
                kept_mask_nxt[i] = (CNT_W'(i) < lc_new);
              end
              n_nxt     = lc_new;
              state_nxt = ST_RM_CHK;
            end else begin
              // newest is always kept
              kept_mask_nxt = '0;
              kept_mask_nxt[IDX_W'(lc_new - CNT_W'(1))] = 1'b1;
              n_nxt     = CNT_W'(1);
              state_nxt = ST_SP_SCAN;
            end
          end
        end
      end

      ST_SP_SCAN, ST_RM_SCAN: begin
        pipe_vld_nxt = 1'b1;
        ptr_nxt      = ptr_r + IDX_W'(1);
        if (ptr_r == last_cand) begin
          state_nxt = (state_r == ST_SP_SCAN) ? ST_SP_END : ST_RM_END;
        end
      end

      ST_SP_END: begin
        state_nxt = ST_RM_CHK;
      end

      ST_RM_CHK: begin
        ptr_nxt  = '0;
        prev_nxt = '0;
        if (8'(n_r) > keep_limit) begin
          first_nxt = 1'b1;
          state_nxt = ST_RM_SCAN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_RM_END: begin
        // drop the lightest candidate found, folding in the final read
        kept_mask_nxt[best_nxt] = 1'b0;
        n_nxt     = n_r - CNT_W'(1);
        state_nxt = ST_RM_CHK;
      end

      ST_EMIT: begin
        if (!kept_mask_r[ptr_r]) begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end else if (!out_valid_r || out_ready) begin
          state_nxt = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        if (ptr_r == last_idx) begin
          load_cnt_nxt  = '0;
          ovf_nxt       = 1'b0;
          kept_mask_nxt = '0;
          ptr_nxt       = '0;
          state_nxt     = ST_LOAD;
        end else begin
          ptr_nxt   = ptr_r + IDX_W'(1);
          state_nxt = ST_EMIT;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_kept_frontier = out_frontier_r;
  assign out_kept_turn     = out_turn_r;
  assign out_source_index  = out_src_r;
  assign out_last_out      = out_last_r;
  assign out_overflow      = out_ovf_r;

endmodule
`default_nettype wire
